@@ design/rtt_pkg.sv @@
// Shared types and constants for the reference-counted tag table.
// No dependencies; used by every other file in the design folder.
`timescale 1ns / 1ps

package rtt_pkg;

   localparam int DEF_ENTRIES = 32;
   localparam int DEV_W       = 16;
   localparam int NUM_W       = 16;
   localparam int CNT_W       = 8;
   localparam int SLOT_W      = 5;

   typedef enum logic [1:0] {
      OP_GET,
      OP_PUT,
      OP_MARK_DIRTY,
      OP_CLEAN
   } op_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_DEV_ZERO,
      ST_NO_FREE,
      ST_PUT_FREE
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SLOT,
      S_VSCAN,
      S_MSCAN,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [DEV_W-1:0] dev;
      logic [NUM_W-1:0] num;
      logic [CNT_W-1:0] count;
      logic             dirty;
   } entry_type;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot;
      logic              hit;
      logic [CNT_W-1:0]  count;
      logic              evict_dirty;
      logic [DEV_W-1:0]  evict_dev;
      logic [NUM_W-1:0]  evict_num;
   } result_type;

   typedef struct packed {
      logic wr_en;
      logic clr_en;
   } mem_ctl_type;

endpackage

@@ design/rtt_entry_mem.sv @@
// Entry memory: one write port, one registered read port, per-entry valid bits.
// An entry that is not valid reads as all zero. Depends on rtt_pkg.
`timescale 1ns / 1ps

module rtt_entry_mem #(
   parameter int ENTRIES = rtt_pkg::DEF_ENTRIES,
   parameter int IDX_W   = $clog2(ENTRIES)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [IDX_W-1:0]        rd_addr,
   output rtt_pkg::entry_type      rd_data,
   input  rtt_pkg::mem_ctl_type    ctl,
   input  logic [IDX_W-1:0]        wr_addr,
   input  rtt_pkg::entry_type      wr_data,
   input  logic [IDX_W-1:0]        clr_addr
);
   import rtt_pkg::*;

   entry_type          mem [ENTRIES];
   logic [ENTRIES-1:0] vld_ff, vld_in;
   entry_type          rd_q_ff;
   logic               rd_vld_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[rd_addr];
   end

   always_comb begin
      vld_in = vld_ff;
      if (ctl.wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
      if (ctl.clr_en) begin
         vld_in[clr_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_vld_ff <= vld_ff[rd_addr];
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

endmodule

@@ design/refcounted_tag_table.sv @@
// Reference-counted tag table with round-robin victim allocation. Depends on
// rtt_pkg and rtt_entry_mem. One transaction at a time through one memory port.
// A get runs a victim scan, then a tag scan, each one entry a cycle; a device-zero
// get skips both scans; put, mark dirty and clean read and update the given slot.
// A new request is accepted only in idle, once the previous result is in the response register.
// Reset clears all entries at once through valid bits and the scan pointer.
`timescale 1ns / 1ps

module refcounted_tag_table #(
   parameter int ENTRIES = rtt_pkg::DEF_ENTRIES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_op,
   input  logic [rtt_pkg::DEV_W-1:0]   req_dev_id,
   input  logic [rtt_pkg::NUM_W-1:0]   req_item_num,
   input  logic [rtt_pkg::SLOT_W-1:0]  req_slot,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [rtt_pkg::SLOT_W-1:0]  rsp_slot_out,
   output logic                        rsp_hit,
   output logic [rtt_pkg::CNT_W-1:0]   rsp_count_out,
   output logic                        rsp_evict_dirty,
   output logic [rtt_pkg::DEV_W-1:0]   rsp_evict_dev,
   output logic [rtt_pkg::NUM_W-1:0]   rsp_evict_num
);
   import rtt_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CTR_W = $clog2(ENTRIES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
   localparam logic [CTR_W-1:0] LAST_CNT = CTR_W'(ENTRIES - 1);
   localparam logic [CTR_W-1:0] ALL_CNT  = CTR_W'(ENTRIES);

   function automatic logic [SLOT_W-1:0] idx_to_slot(input logic [IDX_W-1:0] idx);
      logic [31:0] w;
      w = 32'(idx);
      return w[SLOT_W-1:0];
   endfunction

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [DEV_W-1:0]   dev_ff, dev_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               slot_ok_ff, slot_ok_in;
   logic [IDX_W-1:0]   iss_addr_ff, iss_addr_in;
   logic [CTR_W-1:0]   iss_cnt_ff, iss_cnt_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]   chk_addr_ff, chk_addr_in;
   logic [CTR_W-1:0]   chk_cnt_ff, chk_cnt_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   victim_ff, victim_in;
   logic               vic_dirty_ff, vic_dirty_in;
   logic [DEV_W-1:0]   vic_dev_ff, vic_dev_in;
   logic [NUM_W-1:0]   vic_num_ff, vic_num_in;
   logic [IDX_W-1:0]   scan_ptr_ff, scan_ptr_in;
   result_type         res_ff, res_in;
   result_type         rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [IDX_W-1:0]   rd_addr;
   entry_type          rd_data;
   mem_ctl_type        mem_ctl;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_data;
   logic [IDX_W-1:0]   nxt_addr;
   logic               issue;
   logic [CNT_W-1:0]   sat_count;
   logic [DEV_W-1:0]   evict_dev;
   logic [NUM_W-1:0]   evict_num;

   rtt_entry_mem #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .ctl      (mem_ctl),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .clr_addr (victim_ff)
   );

   assign nxt_addr  = (iss_addr_ff == LAST_IDX) ? '0 : iss_addr_ff + 1'b1;
   assign issue     = (iss_cnt_ff < ALL_CNT);
   assign sat_count = (rd_data.count == '1) ? rd_data.count : rd_data.count + 1'b1;
   assign evict_dev = vic_dirty_ff ? vic_dev_ff : '0;
   assign evict_num = vic_dirty_ff ? vic_num_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_ptr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ptr_ff  <= scan_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_vld_ff   <= chk_vld_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      dev_ff       <= dev_in;
      num_ff       <= num_in;
      slot_ff      <= slot_in;
      slot_ok_ff   <= slot_ok_in;
      iss_addr_ff  <= iss_addr_in;
      iss_cnt_ff   <= iss_cnt_in;
      chk_addr_ff  <= chk_addr_in;
      chk_cnt_ff   <= chk_cnt_in;
      victim_ff    <= victim_in;
      vic_dirty_ff <= vic_dirty_in;
      vic_dev_ff   <= vic_dev_in;
      vic_num_ff   <= vic_num_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      dev_in       = dev_ff;
      num_in       = num_ff;
      slot_in      = slot_ff;
      slot_ok_in   = slot_ok_ff;
      iss_addr_in  = iss_addr_ff;
      iss_cnt_in   = iss_cnt_ff;
      chk_vld_in   = 1'b0;
      chk_addr_in  = chk_addr_ff;
      chk_cnt_in   = chk_cnt_ff;
      found_in     = found_ff;
      victim_in    = victim_ff;
      vic_dirty_in = vic_dirty_ff;
      vic_dev_in   = vic_dev_ff;
      vic_num_in   = vic_num_ff;
      scan_ptr_in  = scan_ptr_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      rd_addr      = IDX_W'(req_slot);
      mem_ctl      = '0;
      wr_addr      = chk_addr_ff;
      wr_data      = rd_data;

      if ((state_ff == S_VSCAN || state_ff == S_MSCAN) && issue) begin
         rd_addr     = nxt_addr;
         iss_addr_in = nxt_addr;
         iss_cnt_in  = iss_cnt_ff + 1'b1;
         chk_vld_in  = 1'b1;
         chk_addr_in = nxt_addr;
      end

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in       = op_type'(req_op);
               dev_in      = req_dev_id;
               num_in      = req_item_num;
               slot_in     = req_slot;
               slot_ok_in  = (32'(req_slot) < 32'(ENTRIES));
               iss_addr_in = scan_ptr_ff;
               iss_cnt_in  = '0;
               chk_cnt_in  = '0;
               found_in    = 1'b0;
               if (op_type'(req_op) != OP_GET) begin
                  state_in = S_SLOT;
               end else if (req_dev_id == '0) begin
                  res_in        = '0;
                  res_in.status = ST_DEV_ZERO;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_VSCAN;
               end
            end
         end
         S_SLOT: begin
            res_in      = '0;
            res_in.slot = slot_ff;
            wr_addr     = IDX_W'(slot_ff);
            if (!slot_ok_ff) begin
               res_in.status = (op_ff == OP_PUT) ? ST_PUT_FREE : ST_OK;
            end else begin
               unique case (op_ff)
                  OP_PUT: begin
                     if (rd_data.count == '0) begin
                        res_in.status = ST_PUT_FREE;
                     end else begin
                        wr_data.count = rd_data.count - 1'b1;
                        mem_ctl.wr_en = 1'b1;
                        res_in.count  = rd_data.count - 1'b1;
                     end
                  end
                  OP_MARK_DIRTY: begin
                     wr_data.dirty = 1'b1;
                     mem_ctl.wr_en = 1'b1;
                     res_in.count  = rd_data.count;
                  end
                  OP_CLEAN: begin
                     wr_data.dirty = 1'b0;
                     mem_ctl.wr_en = 1'b1;
                     res_in.count  = rd_data.count;
                  end
                  default: ;
               endcase
            end
            state_in = S_RESP;
         end
         S_VSCAN: begin
            if (chk_vld_ff) begin
               chk_cnt_in = chk_cnt_ff + 1'b1;
               if (rd_data.count == '0) begin
                  found_in     = 1'b1;
                  victim_in    = chk_addr_ff;
                  vic_dirty_in = rd_data.dirty;
                  vic_dev_in   = rd_data.dev;
                  vic_num_in   = rd_data.num;
               end
               if ((rd_data.count == '0 && !rd_data.dirty) || chk_cnt_ff == LAST_CNT) begin
                  if (rd_data.count == '0 && !rd_data.dirty) begin
                     scan_ptr_in = chk_addr_ff;
                  end
                  if (found_ff || rd_data.count == '0) begin
                     state_in    = S_MSCAN;
                     iss_addr_in = LAST_IDX;
                     iss_cnt_in  = '0;
                     chk_vld_in  = 1'b0;
                     chk_cnt_in  = '0;
                  end else begin
                     res_in        = '0;
                     res_in.status = ST_NO_FREE;
                     chk_vld_in    = 1'b0;
                     state_in      = S_RESP;
                  end
               end
            end
         end
         S_MSCAN: begin
            if (chk_vld_ff) begin
               chk_cnt_in = chk_cnt_ff + 1'b1;
               if (rd_data.dev == dev_ff && rd_data.num == num_ff &&
                   chk_addr_ff != victim_ff) begin
                  wr_addr            = chk_addr_ff;
                  wr_data.count      = sat_count;
                  mem_ctl.wr_en      = 1'b1;
                  mem_ctl.clr_en     = 1'b1;
                  res_in.status      = ST_OK;
                  res_in.slot        = idx_to_slot(chk_addr_ff);
                  res_in.hit         = 1'b1;
                  res_in.count       = sat_count;
                  res_in.evict_dirty = vic_dirty_ff;
                  res_in.evict_dev   = evict_dev;
                  res_in.evict_num   = evict_num;
                  chk_vld_in         = 1'b0;
                  state_in           = S_RESP;
               end else if (chk_cnt_ff == LAST_CNT) begin
                  wr_addr            = victim_ff;
                  wr_data.dev        = dev_ff;
                  wr_data.num        = num_ff;
                  wr_data.count      = CNT_W'(1);
                  wr_data.dirty      = 1'b0;
                  mem_ctl.wr_en      = 1'b1;
                  res_in.status      = ST_OK;
                  res_in.slot        = idx_to_slot(victim_ff);
                  res_in.hit         = 1'b0;
                  res_in.count       = CNT_W'(1);
                  res_in.evict_dirty = vic_dirty_ff;
                  res_in.evict_dev   = evict_dev;
                  res_in.evict_num   = evict_num;
                  chk_vld_in         = 1'b0;
                  state_in           = S_RESP;
               end
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_slot_out    = rsp_ff.slot;
   assign rsp_hit         = rsp_ff.hit;
   assign rsp_count_out   = rsp_ff.count;
   assign rsp_evict_dirty = rsp_ff.evict_dirty;
   assign rsp_evict_dev   = rsp_ff.evict_dev;
   assign rsp_evict_num   = rsp_ff.evict_num;

endmodule

@@ design/rtt_checker.sv @@
// Port-level checks for refcounted_tag_table, attached by the bind below.
// Depends on rtt_pkg and on the top level's port names.
`timescale 1ns / 1ps

module rtt_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [1:0]                  rsp_status,
   input logic [rtt_pkg::SLOT_W-1:0]  rsp_slot_out,
   input logic                        rsp_hit,
   input logic [rtt_pkg::CNT_W-1:0]   rsp_count_out,
   input logic                        rsp_evict_dirty,
   input logic [rtt_pkg::DEV_W-1:0]   rsp_evict_dev,
   input logic [rtt_pkg::NUM_W-1:0]   rsp_evict_num
);
   import rtt_pkg::*;

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a transaction is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot_out))
      else $error("stalled response dropped or changed");

   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_status == ST_OK && rsp_count_out != '0)
      else $error("hit without ok status or with zero count");

   a_evict_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evict_dirty |-> rsp_evict_dev == '0 && rsp_evict_num == '0)
      else $error("eviction tags without dirty victim");

endmodule

bind refcounted_tag_table rtt_checker u_rtt_checker (.*);

@@ verif/refcounted_tag_table_test.sv @@
// Self-checking testbench for refcounted_tag_table: drives get/put/dirty/clean traffic,
// predicts each response from a shadow copy of the table and compares in order.
// Depends on rtt_pkg and refcounted_tag_table from the design folder.
`timescale 1ns / 1ps

module refcounted_tag_table_test;
   import rtt_pkg::*;

   localparam int DEPTH = DEF_ENTRIES;
   localparam int ITEMS = 1500;
   localparam int LIMIT = 1500000;

   typedef struct {
      op_type            op;
      logic [DEV_W-1:0]  dev;
      logic [NUM_W-1:0]  num;
      logic [SLOT_W-1:0] slot;
   } lookup_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_op = OP_GET;
   logic [DEV_W-1:0] req_dev_id = '0;
   logic [NUM_W-1:0] req_item_num = '0;
   logic [SLOT_W-1:0] req_slot = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [SLOT_W-1:0] rsp_slot_out;
   logic rsp_hit;
   logic [CNT_W-1:0] rsp_count_out;
   logic rsp_evict_dirty;
   logic [DEV_W-1:0] rsp_evict_dev;
   logic [NUM_W-1:0] rsp_evict_num;

   // shadow table
   logic [DEV_W-1:0] tbl_dev [DEPTH];
   logic [NUM_W-1:0] tbl_num [DEPTH];
   logic [CNT_W-1:0] tbl_cnt [DEPTH];
   logic             tbl_dirty [DEPTH];
   int               tbl_scan;

   lookup_req_type req_backlog [$];
   result_type     due_results [$];
   result_type     rsp_want;
   result_type     rsp_got;
   lookup_req_type req_next;
   int issued = 0;
   int errors = 0;
   int cycles = 0;
   int send_idle = 0;
   int recv_stall = 0;
   bit calm = 1'b0;

   refcounted_tag_table i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_dev_id(req_dev_id),
      .req_item_num(req_item_num),
      .req_slot(req_slot),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_slot_out(rsp_slot_out),
      .rsp_hit(rsp_hit),
      .rsp_count_out(rsp_count_out),
      .rsp_evict_dirty(rsp_evict_dirty),
      .rsp_evict_dev(rsp_evict_dev),
      .rsp_evict_num(rsp_evict_num)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic result_type lookup_result(op_type op, logic [DEV_W-1:0] dev,
                                                logic [NUM_W-1:0] num,
                                                logic [SLOT_W-1:0] slot);
      result_type r;
      int p;
      int victim;
      int match;
      bit found;
      r = '0;
      r.status = ST_OK;
      if (op == OP_GET) begin
         if (dev == 0) begin
            r.status = ST_DEV_ZERO;
            return r;
         end
         p = tbl_scan;
         victim = 0;
         found = 1'b0;
         for (int i = 0; i < DEPTH; i++) begin
            p = (p + 1) % DEPTH;
            if (tbl_cnt[p] == 0) begin
               victim = p;
               found = 1'b1;
               if (!tbl_dirty[p]) break;
            end
         end
         tbl_scan = p;
         if (!found) begin
            r.status = ST_NO_FREE;
            return r;
         end
         if (tbl_dirty[victim]) begin
            r.evict_dirty = 1'b1;
            r.evict_dev = tbl_dev[victim];
            r.evict_num = tbl_num[victim];
         end
         tbl_dev[victim] = '0;
         tbl_num[victim] = '0;
         tbl_dirty[victim] = 1'b0;
         tbl_cnt[victim] = CNT_W'(1);
         match = -1;
         for (int i = 0; i < DEPTH; i++) begin
            if (match < 0 && tbl_dev[i] == dev && tbl_num[i] == num) match = i;
         end
         if (match >= 0) begin
            if (tbl_cnt[match] != 8'hFF) tbl_cnt[match] = tbl_cnt[match] + 1'b1;
            tbl_cnt[victim] = '0;
            r.slot = SLOT_W'(match);
            r.hit = 1'b1;
            r.count = tbl_cnt[match];
         end else begin
            tbl_dev[victim] = dev;
            tbl_num[victim] = num;
            r.slot = SLOT_W'(victim);
            r.count = tbl_cnt[victim];
         end
         return r;
      end
      r.slot = slot;
      if (slot >= DEPTH) begin
         if (op == OP_PUT) r.status = ST_PUT_FREE;
         return r;
      end
      case (op)
         OP_PUT: begin
            if (tbl_cnt[slot] == 0) begin
               r.status = ST_PUT_FREE;
               return r;
            end
            tbl_cnt[slot] = tbl_cnt[slot] - 1'b1;
         end
         OP_MARK_DIRTY: tbl_dirty[slot] = 1'b1;
         default: tbl_dirty[slot] = 1'b0;
      endcase
      r.count = tbl_cnt[slot];
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic int pick_held();
      int held [$];
      for (int i = 0; i < DEPTH; i++) begin
         if (tbl_cnt[i] != 0) held.push_back(i);
      end
      if (held.size() == 0) return $urandom_range(0, DEPTH - 1);
      return held[$urandom_range(0, held.size() - 1)];
   endfunction

   task automatic queue_req(op_type op, logic [DEV_W-1:0] dev, logic [NUM_W-1:0] num,
                            logic [SLOT_W-1:0] slot);
      lookup_req_type t;
      t.op = op;
      t.dev = dev;
      t.num = num;
      t.slot = slot;
      req_backlog.push_back(t);
      issued++;
   endtask

   task automatic queue_other(op_type op, int slot);
      queue_req(op, DEV_W'($urandom_range(0, 65535)), NUM_W'($urandom_range(0, 65535)),
                SLOT_W'(slot));
   endtask

   task automatic queue_get(int dev, int num);
      queue_req(OP_GET, DEV_W'(dev), NUM_W'(num), SLOT_W'($urandom_range(0, DEPTH - 1)));
   endtask

   task automatic wait_drain();
      while (req_backlog.size() != 0 || req_valid) @(negedge clock);
   endtask

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         tbl_dev[i] = '0;
         tbl_num[i] = '0;
         tbl_cnt[i] = '0;
         tbl_dirty[i] = 1'b0;
      end
      tbl_scan = 0;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_idle <= 0;
      end else begin
         if (req_valid && req_ready)
            due_results.push_back(lookup_result(op_type'(req_op), req_dev_id, req_item_num,
                                                req_slot));
         if (!req_valid || req_ready) begin
            if (send_idle != 0) begin
               req_valid <= 1'b0;
               send_idle <= send_idle - 1;
            end else if (req_backlog.size() != 0) begin
               req_next = req_backlog.pop_front();
               req_op <= req_next.op;
               req_dev_id <= req_next.dev;
               req_item_num <= req_next.num;
               req_slot <= req_next.slot;
               req_valid <= 1'b1;
               send_idle <= calm ? 0 : pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_stall <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected transaction: status %0d slot %0d count %0d",
                           rsp_status, rsp_slot_out, rsp_count_out);
            end else begin
               rsp_want = due_results.pop_front();
               rsp_got.status = status_type'(rsp_status);
               rsp_got.slot = rsp_slot_out;
               rsp_got.hit = rsp_hit;
               rsp_got.count = rsp_count_out;
               rsp_got.evict_dirty = rsp_evict_dirty;
               rsp_got.evict_dev = rsp_evict_dev;
               rsp_got.evict_num = rsp_evict_num;
               if (rsp_got !== rsp_want) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("mismatch: expected st %0d slot %0d hit %0d cnt %0d ev %0d %h/%h",
                              rsp_want.status, rsp_want.slot, rsp_want.hit, rsp_want.count,
                              rsp_want.evict_dirty, rsp_want.evict_dev, rsp_want.evict_num);
                     $display("          actual   st %0d slot %0d hit %0d cnt %0d ev %0d %h/%h",
                              rsp_got.status, rsp_got.slot, rsp_got.hit, rsp_got.count,
                              rsp_got.evict_dirty, rsp_got.evict_dev, rsp_got.evict_num);
                  end
               end
            end
         end
         if (recv_stall != 0) begin
            rsp_ready <= 1'b0;
            recv_stall <= recv_stall - 1;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) recv_stall <= pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int n;
      int s;
      bit sat_done;
      sat_done = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_req(OP_GET, 16'h0000, 16'hFFFF, 5'h1F);
      queue_get('hFFFF, 'hFFFF);
      queue_get('hFFFF, 'hFFFF);
      queue_get(1, 0);
      queue_other(OP_PUT, 1);
      queue_other(OP_PUT, 1);
      queue_other(OP_PUT, 1);
      queue_get('hFFFF, 'hFFFF);
      queue_other(OP_MARK_DIRTY, 1);
      queue_other(OP_PUT, 1);
      queue_other(OP_CLEAN, 31);
      queue_other(OP_MARK_DIRTY, 31);
      queue_other(OP_PUT, 0);
      queue_other(OP_CLEAN, 0);
      queue_get('h8000, 1);
      queue_get(1, 0);
      queue_other(OP_MARK_DIRTY, 0);
      queue_other(OP_CLEAN, 0);
      queue_get('hFFFF, 'hFFFF);
      queue_other(OP_PUT, 31);

      while (issued < ITEMS) begin
         while (req_backlog.size() > 2) @(negedge clock);
         calm = ($urandom_range(0, 9) == 0);
         if (!sat_done && issued >= 600) begin
            // drive one tag past the count ceiling
            sat_done = 1'b1;
            repeat (260) queue_get('hAB, 'hCD0);
            wait_drain();
            repeat (5) queue_other(OP_PUT, pick_held());
         end else begin
            n = $urandom_range(0, 99);
            if (n < 40) begin
               repeat ($urandom_range(1, 4))
                  queue_get(($urandom_range(0, 29) == 0) ? 0 : $urandom_range(1, 4),
                            $urandom_range(0, 7));
               wait_drain();
               repeat ($urandom_range(1, 4)) queue_other(OP_PUT, pick_held());
            end else if (n < 55) begin
               wait_drain();
               s = pick_held();
               queue_other(OP_MARK_DIRTY, s);
               repeat ($urandom_range(1, 2)) queue_other(OP_PUT, s);
            end else if (n < 65) begin
               repeat ($urandom_range(1, 3))
                  queue_other($urandom_range(0, 1) ? OP_MARK_DIRTY : OP_CLEAN,
                              $urandom_range(0, DEPTH - 1));
            end else if (n < 80) begin
               repeat ($urandom_range(1, 4))
                  queue_req(op_type'($urandom_range(0, 3)),
                            ($urandom_range(0, 4) == 0) ? '0 :
                               DEV_W'($urandom_range(0, 65535)),
                            NUM_W'($urandom_range(0, 65535)),
                            SLOT_W'($urandom_range(0, DEPTH - 1)));
            end else if (n < 95) begin
               repeat ($urandom_range(1, 3))
                  queue_get($urandom_range(1, 65535), $urandom_range(0, 65535));
            end else begin
               // fill the table, free a few entries dirty, then evict them
               repeat ($urandom_range(34, 40))
                  queue_get($urandom_range(1, 65535), $urandom_range(0, 65535));
               wait_drain();
               repeat ($urandom_range(1, 4)) begin
                  s = pick_held();
                  queue_other(OP_MARK_DIRTY, s);
                  repeat (tbl_cnt[s] > 3 ? 3 : tbl_cnt[s]) queue_other(OP_PUT, s);
                  wait_drain();
               end
               repeat ($urandom_range(1, 4))
                  queue_get($urandom_range(1, 65535), $urandom_range(0, 65535));
               wait_drain();
               for (int i = 0; i < DEPTH; i++) begin
                  if (tbl_cnt[i] != 0 && $urandom_range(0, 3) != 0) queue_other(OP_PUT, i);
               end
            end
         end
      end

      while (req_backlog.size() != 0 || req_valid || due_results.size() != 0)
         @(posedge clock);
      repeat (2 * DEPTH + 8) @(posedge clock);
      if (due_results.size() != 0) errors++;
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
